>>> hdl/mexp_pkg.sv
// shared constants and control types for the modular exponentiation block
// no dependencies; imported by the interfaces and every module

package mexp_pkg;

    // width of the request and response payload fields
    localparam int DATA_BITS     = 64;
    // default operand width used inside the datapath
    localparam int WORD_BITS_DEF = 64;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture a new request
        logic red_step;    // one step of the base reduction
        logic red_last;    // last reduction step, base takes the remainder
        logic mm_ld_mul;   // start a product result * base
        logic mm_ld_sqr;   // start a product base * base
        logic mm_step;     // one shift-add step of the modular product
        logic mm_wr_r;     // write finished product into the result register
        logic mm_wr_b;     // write finished square into base, shift exponent
        logic out_load;    // move the result into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic m_zero;      // modulus is zero
        logic e_zero;      // no exponent bits left
        logic e_lsb;       // current exponent bit
    } t_status;

endpackage

>>> hdl/mexp_ifs.sv
// valid/ready channel interfaces for requests and responses
// depends on mexp_pkg

interface mexp_req_if;
    import mexp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] base;
    logic [DATA_BITS-1:0] exponent;
    logic [DATA_BITS-1:0] modulus;

    modport source (output valid, output base, output exponent, output modulus, input ready);
    modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

interface mexp_rsp_if;
    import mexp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] result;
    logic                 bad_modulus;

    modport source (output valid, output result, output bad_modulus, input ready);
    modport sink   (input valid, input result, input bad_modulus, output ready);
endinterface

>>> hdl/modular_exponentiation_64_top.sv
// Modular exponentiation, base ** exponent mod modulus, on WORD_BITS-bit operands
// (low WORD_BITS bits of each 64-bit request field; default 64). One request gives
// one response. A request is taken only while the block is idle; the response sits
// in an output register, so the next request is accepted while it waits. Steps after
// acceptance: check the modulus, reduce the base below the modulus (one quotient bit
// a cycle), then for every exponent bit up to the highest set one: test the bit and
// square, and when the bit is set, multiply first and load the squaring after it;
// finally the test that finds no bits left and the hand-off. The time taken is set by
// the bit-serial modular adder/doubler in the datapath, which does one multiplier bit
// per cycle. A modulus of zero goes straight to the hand-off, with result 0 and
// bad_modulus set; modulus one always gives 0. Exponent zero gives 1 mod modulus.
// depends on mexp_pkg, mexp_ifs, mexp_ctrl and mexp_datapath

module modular_exponentiation_64_top #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mexp_req_if.sink    i_req,
    mexp_rsp_if.source  o_rsp
);
    import mexp_pkg::*;

    t_cmd                 cmd;
    t_status              st;
    logic [WORD_BITS-1:0] result;
    logic                 req_ready;
    logic                 rsp_valid;
    logic                 bad_modulus;

    // controller: sequences reduction, bit scan and the two product kinds
    mexp_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (rsp_valid),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    // datapath: operand registers and the shift-add modular arithmetic
    mexp_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_base        (i_req.base),
        .i_exponent    (i_req.exponent),
        .i_modulus     (i_req.modulus),
        .o_st          (st),
        .o_result      (result),
        .o_bad_modulus (bad_modulus)
    );

    assign i_req.ready       = req_ready;
    assign o_rsp.valid       = rsp_valid;
    // operands narrower than the port are zero-extended
    assign o_rsp.result      = DATA_BITS'(result);
    assign o_rsp.bad_modulus = bad_modulus;

    // a zero modulus must always come back as a zero result
    a_bad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.bad_modulus) |-> (o_rsp.result == '0))
        else $error("bad modulus response with nonzero result");

    // reduction and product steps never share a cycle
    a_one_unit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.red_step && cmd.mm_step))
        else $error("reduction and product step issued together");

    // loading the output register always presents a response next cycle
    a_out_load : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_rsp.valid)
        else $error("response not valid after output load");

    // a new request is never captured while a computation is in flight
    a_load_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.mm_step || cmd.red_step) |-> !i_req.ready)
        else $error("request port open during computation");

endmodule

>>> hdl/mexp_datapath.sv
// operand registers, bit-serial modular adder/doubler, reduction step, output register
// depends on mexp_pkg; driven by mexp_ctrl through t_cmd

module mexp_datapath #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  mexp_pkg::t_cmd                    i_cmd,
    input  logic [mexp_pkg::DATA_BITS-1:0]    i_base,
    input  logic [mexp_pkg::DATA_BITS-1:0]    i_exponent,
    input  logic [mexp_pkg::DATA_BITS-1:0]    i_modulus,
    output mexp_pkg::t_status                 o_st,
    output logic [WORD_BITS-1:0]              o_result,
    output logic                              o_bad_modulus
);
    import mexp_pkg::*;

    logic [WORD_BITS-1:0] r_m;
    logic [WORD_BITS-1:0] r_e;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_x;
    logic [WORD_BITS-1:0] r_y;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_r;
    logic [WORD_BITS-1:0] r_res;
    logic                 r_bad;

    logic [WORD_BITS:0]   red_t;
    logic [WORD_BITS:0]   red_d;
    logic [WORD_BITS-1:0] red_next;
    logic [WORD_BITS-1:0] room;
    logic [WORD_BITS-1:0] acc_add;
    logic [WORD_BITS-1:0] acc_next;
    logic [WORD_BITS-1:0] x_next;

    // restoring remainder step: shift in next base bit, subtract modulus if it fits
    always_comb begin
        red_t    = {r_acc, r_b[WORD_BITS-1]};
        red_d    = red_t - {1'b0, r_m};
        red_next = (red_t >= {1'b0, r_m}) ? red_d[WORD_BITS-1:0] : red_t[WORD_BITS-1:0];
    end

    // (acc + x) mod m and (2x) mod m without overflow, operands below m
    always_comb begin
        room     = r_m - r_x;
        acc_add  = (r_acc >= room) ? (r_acc - room) : (r_acc + r_x);
        acc_next = r_y[0] ? acc_add : r_acc;
        x_next   = (r_x >= room) ? (r_x - room) : (r_x + r_x);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m   <= i_modulus[WORD_BITS-1:0];
            r_e   <= i_exponent[WORD_BITS-1:0];
            r_b   <= i_base[WORD_BITS-1:0];
            r_acc <= '0;
            // 1 mod m: zero for modulus one, and for modulus zero the forced result
            r_r   <= WORD_BITS'(i_modulus[WORD_BITS-1:0] > WORD_BITS'(1));
        end else if (i_cmd.red_step) begin
            r_acc <= red_next;
            if (i_cmd.red_last) begin
                r_b <= red_next;
            end else begin
                r_b <= r_b << 1;
            end
        end else if (i_cmd.mm_ld_mul) begin
            r_acc <= '0;
            r_x   <= r_r;
            r_y   <= r_b;
        end else if (i_cmd.mm_ld_sqr) begin
            r_acc <= '0;
            r_x   <= r_b;
            r_y   <= r_b;
        end else if (i_cmd.mm_step) begin
            r_acc <= acc_next;
            r_x   <= x_next;
            r_y   <= r_y >> 1;
            if (i_cmd.mm_wr_r) begin
                r_r <= acc_next;
            end
            if (i_cmd.mm_wr_b) begin
                r_b <= acc_next;
                r_e <= r_e >> 1;
            end
        end
        if (i_cmd.out_load) begin
            r_res <= r_r;
            r_bad <= (r_m == '0);
        end
    end

    assign o_st.m_zero   = (r_m == '0);
    assign o_st.e_zero   = (r_e == '0);
    assign o_st.e_lsb    = r_e[0];
    assign o_result      = r_res;
    assign o_bad_modulus = r_bad;

endmodule

>>> hdl/mexp_ctrl.sv
// sequencing state machine: reduction, square-and-multiply scan, response handoff
// depends on mexp_pkg; drives mexp_datapath through t_cmd

module mexp_ctrl #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic              i_rsp_ready,
    output logic              o_rsp_valid,
    input  mexp_pkg::t_status i_st,
    output mexp_pkg::t_cmd    o_cmd
);
    import mexp_pkg::*;

    localparam int CW = $clog2(WORD_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_RED  = 3'd2;
    localparam logic [2:0] S_BIT  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SQLD = 3'd5;
    localparam logic [2:0] S_SQR  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          cnt_last;

    assign cnt_last = (r_cnt == CW'(WORD_BITS - 1));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_rsp_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                n_cnt   = '0;
                n_state = i_st.m_zero ? S_FIN : S_RED;
            end
            S_RED: begin
                o_cmd.red_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (cnt_last) begin
                    o_cmd.red_last = 1'b1;
                    n_state        = S_BIT;
                end
            end
            S_BIT: begin
                n_cnt = '0;
                if (i_st.e_zero) begin
                    n_state = S_FIN;
                end else if (i_st.e_lsb) begin
                    o_cmd.mm_ld_mul = 1'b1;
                    n_state         = S_MUL;
                end else begin
                    o_cmd.mm_ld_sqr = 1'b1;
                    n_state         = S_SQR;
                end
            end
            S_MUL: begin
                o_cmd.mm_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (cnt_last) begin
                    o_cmd.mm_wr_r = 1'b1;
                    n_state       = S_SQLD;
                end
            end
            S_SQLD: begin
                o_cmd.mm_ld_sqr = 1'b1;
                n_cnt           = '0;
                n_state         = S_SQR;
            end
            S_SQR: begin
                o_cmd.mm_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (cnt_last) begin
                    o_cmd.mm_wr_b = 1'b1;
                    n_state       = S_BIT;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

endmodule

>>> sim/mexp_power_checker.sv
`timescale 1ns / 100ps
// checker for the modular exponentiation block: watches both channels, predicts
// base ** exponent mod modulus for each request and compares responses in order
// depends on mexp_pkg and mexp_ifs

module mexp_power_checker #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mexp_req_if  i_req,
    mexp_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import mexp_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [DATA_BITS-1:0] result;
        logic                 bad_modulus;
    } t_power;

    t_power expected_powers[$];

    // square-and-multiply over the exponent, each product reduced by the modulus
    function automatic t_power power_mod(input logic [DATA_BITS-1:0] base,
                                         input logic [DATA_BITS-1:0] exponent,
                                         input logic [DATA_BITS-1:0] modulus);
        t_power               res;
        logic [DATA_BITS-1:0] word_mask;
        logic [DATA_BITS-1:0] b;
        logic [DATA_BITS-1:0] e;
        logic [DATA_BITS-1:0] m;
        logic [DATA_BITS-1:0] acc;
        logic [DATA_BITS-1:0] sq;
        logic [2*DATA_BITS-1:0] wide;
        int                   i;
        word_mask = {DATA_BITS{1'b1}} >> (DATA_BITS - WORD_BITS);
        b = base & word_mask;
        e = exponent & word_mask;
        m = modulus & word_mask;
        if (m == '0) begin
            res.result      = '0;
            res.bad_modulus = 1'b1;
            return res;
        end
        acc = (m == 1) ? '0 : 1;
        sq  = b % m;
        for (i = 0; i < WORD_BITS; i++) begin
            if (e[i]) begin
                wide = {{DATA_BITS{1'b0}}, acc} * {{DATA_BITS{1'b0}}, sq};
                wide = wide % {{DATA_BITS{1'b0}}, m};
                acc  = wide[DATA_BITS-1:0];
            end
            wide = {{DATA_BITS{1'b0}}, sq} * {{DATA_BITS{1'b0}}, sq};
            wide = wide % {{DATA_BITS{1'b0}}, m};
            sq   = wide[DATA_BITS-1:0];
        end
        res.result      = acc;
        res.bad_modulus = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_power want;
        if (!i_rst_n) begin
            // counters start clean while reset is held
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                expected_powers.push_back(power_mod(i_req.base, i_req.exponent,
                                                    i_req.modulus));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_powers.size() == 0) begin
                    if (o_fail_count < REPORT_MAX) begin
                        $display("unexpected response: result %h bad_modulus %b",
                                 i_rsp.result, i_rsp.bad_modulus);
                    end
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_powers.pop_front();
                    if (want.result !== i_rsp.result
                            || want.bad_modulus !== i_rsp.bad_modulus) begin
                        if (o_fail_count < REPORT_MAX) begin
                            $display("mismatch: expected result %h bad_modulus %b",
                                     want.result, want.bad_modulus);
                            $display("          actual   result %h bad_modulus %b",
                                     i_rsp.result, i_rsp.bad_modulus);
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending = expected_powers.size();
        end
    end

endmodule

>>> sim/tb_modular_exponentiation_64_top.sv
`timescale 1ns / 100ps
// testbench top for modular_exponentiation_64_top: drives directed and random
// requests, paces the response side and reports the verdict from the checker
// depends on mexp_pkg, mexp_ifs, mexp_power_checker and the block itself

module tb_modular_exponentiation_64_top;
    import mexp_pkg::*;

    // run shape
    localparam int N_RANDOM     = 78;
    localparam int IDLE_PCT     = 21;
    localparam int HOLD_CYCLES  = 4000;   // long receiver hold-off, several small requests
    localparam int BURST_ITEMS  = 5;
    localparam int DRAIN_CYCLES = 200;
    // allow for the worst request, hold-off and idling many times over
    localparam int unsigned CYCLE_LIMIT = 6_000_000;

    localparam logic [DATA_BITS-1:0] ALL_ONES = {DATA_BITS{1'b1}};
    // largest 64-bit prime, used for a fermat check
    localparam logic [DATA_BITS-1:0] PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;

    // set by the stimulus to quiet both sides for a stretch
    bit          steady = 1'b0;
    // each increment asks the receiver for one long hold-off
    int          hold_token = 0;

    mexp_req_if req_if ();
    mexp_rsp_if rsp_if ();

    modular_exponentiation_64_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    mexp_power_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // hard stop if the block hangs or a response never comes
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_modular_exponentiation_64_top failed");
            $finish;
        end
    end

    function automatic logic [DATA_BITS-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // random value whose highest possible set bit is bits-1
    function automatic logic [DATA_BITS-1:0] rand_bits(input int bits);
        return rand_word() >> (DATA_BITS - bits);
    endfunction

    // present one request, with random idle cycles first; called and returns at a
    // falling edge, so valid and the payload only change there
    task automatic send_request(input logic [DATA_BITS-1:0] base,
                                input logic [DATA_BITS-1:0] exponent,
                                input logic [DATA_BITS-1:0] modulus);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            // idle cycle, junk on the payload
            req_if.valid    <= 1'b0;
            req_if.base     <= rand_word();
            req_if.exponent <= rand_word();
            req_if.modulus  <= rand_word();
            @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.base     <= base;
        req_if.exponent <= exponent;
        req_if.modulus  <= modulus;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender pauses until every outstanding response has come back
    task automatic wait_all_responses();
        while (pending != 0) @(negedge i_clk);
    endtask

    // receiver: random back-pressure, plus one long hold-off per token
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                rsp_if.ready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
            end else begin
                rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // stimulus and verdict
    initial begin
        logic [DATA_BITS-1:0] b;
        logic [DATA_BITS-1:0] e;
        logic [DATA_BITS-1:0] m;
        int                   n;
        int                   k;

        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.base     = '0;
        req_if.exponent = '0;
        req_if.modulus  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero modulus, flag set whatever the other fields hold
        send_request(rand_word(), rand_word(), '0);
        send_request(ALL_ONES, ALL_ONES, '0);
        send_request('0, '0, '0);
        // modulus one always gives zero
        send_request(rand_word(), rand_bits(8), 64'd1);
        send_request(rand_word(), '0, 64'd1);
        // exponent zero gives one, zero to the zero included
        send_request(rand_word(), '0, 64'd7);
        send_request('0, '0, ALL_ONES);
        // base not below modulus needs the reduction first
        send_request(64'd100, 64'd5, 64'd7);
        send_request(ALL_ONES, 64'd3, ALL_ONES);
        send_request(ALL_ONES, 64'd9, ALL_ONES - 1);
        // zero and one as base
        send_request('0, rand_bits(12), rand_word());
        send_request(64'd1, ALL_ONES, rand_word());
        // exponent one
        send_request(rand_word(), 64'd1, rand_word());
        // full-width extremes, the slowest requests
        send_request(ALL_ONES - 1, ALL_ONES, ALL_ONES);
        send_request(64'd2, PRIME_64 - 1, PRIME_64);
        send_request(rand_word(), ALL_ONES, 64'd13);
        send_request(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000, PRIME_64);

        // let the pipe empty before the pressure test
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        wait_all_responses();

        // long receiver stall while small requests keep coming: the output register
        // fills, the next request completes behind it and the input backs up
        @(posedge i_clk);
        hold_token = hold_token + 1;
        @(negedge i_clk);
        for (k = 0; k < BURST_ITEMS; k++) begin
            send_request(rand_word(), rand_bits($urandom_range(1, 6)), rand_word());
        end

        // random part: mostly short exponents to keep the run short, a few full ones
        for (k = 0; k < N_RANDOM; k++) begin
            // a stretch with no idling on either side
            steady = (k >= 30 && k < 50);

            case ($urandom_range(9))
                0:       n = 64;
                1, 2:    n = $urandom_range(13, 32);
                default: n = $urandom_range(1, 12);
            endcase
            e = rand_bits(n);

            case ($urandom_range(19))
                0:       m = '0;
                1:       m = 64'd1;
                2:       m = ALL_ONES;
                3, 4:    m = $urandom_range(2, 1000);
                default: m = rand_word();
            endcase

            case ($urandom_range(19))
                0:       b = '0;
                1:       b = ALL_ONES;
                2:       b = m;
                3:       b = $urandom_range(1, 1000);
                default: b = rand_word();
            endcase

            send_request(b, e, m);

            // second drain mid-run
            if (k == 70) begin
                req_if.valid <= 1'b0;
                @(negedge i_clk);
                wait_all_responses();
            end
        end
        steady = 1'b0;
        req_if.valid <= 1'b0;

        wait_all_responses();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_modular_exponentiation_64_top passed");
        end else begin
            $display("tb_modular_exponentiation_64_top failed");
        end
        $finish;
    end

endmodule
